@@ rtl/spt_pkg.sv @@
// Shared types and constants for the segmented page-table MMU.
// Used by spt_ctrl, spt_dp and segment_page_table_mmu_unit; depends on nothing.
package spt_pkg;

	localparam logic [2:0] OP_TRANSLATE = 3'd0;
	localparam logic [2:0] OP_PAGE_WR   = 3'd1;
	localparam logic [2:0] OP_PAGE_RD   = 3'd2;
	localparam logic [2:0] OP_BASE_WR   = 3'd3;
	localparam logic [2:0] OP_LIMIT_WR  = 3'd4;
	localparam logic [2:0] OP_BASE_RD   = 3'd5;
	localparam logic [2:0] OP_LIMIT_RD  = 3'd6;

	localparam logic [1:0] SEG_TEXT   = 2'd0;
	localparam logic [1:0] SEG_STACK  = 2'd1;
	localparam logic [1:0] SEG_KERNEL = 2'd2;
	localparam logic [1:0] SEG_NONE   = 2'd3;

	localparam logic [1:0] FAULT_NONE   = 2'd0;
	localparam logic [1:0] FAULT_LIMIT  = 2'd1;
	localparam logic [1:0] FAULT_NOPROT = 2'd2;
	localparam logic [1:0] FAULT_RAM    = 2'd3;

	localparam logic [13:0] PAGE_FIELD_MASK = 14'h3fff;

	// Stored entry: {entry[31:28], entry[12:0]}
	localparam int ENTRY_W = 17;

	typedef struct packed {
		logic clear;
		logic idle;
		logic lookup;
		logic finish;
	} spt_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_hold;
	} spt_sts_t;

endpackage

@@ rtl/spt_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module spt_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/spt_ctrl.sv @@
// Controller state machine: table clear after reset, then accept, lookup, finish.
// Depends on spt_pkg.
module spt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  spt_pkg::spt_sts_t sts,
	output spt_pkg::spt_cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_ADDR  = 2'd2;
	localparam logic [1:0] ST_DATA  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_ADDR;
			end
			ST_ADDR: begin
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (!sts.out_hold) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.clear  = (state_q == ST_CLEAR);
	assign cmd.idle   = (state_q == ST_IDLE);
	assign cmd.lookup = (state_q == ST_ADDR);
	assign cmd.finish = (state_q == ST_DATA) && !sts.out_hold;

endmodule

@@ rtl/spt_dp.sv @@
// Datapath: request capture, segment registers, page-table RAM, fault checks, result register.
// Depends on spt_pkg and spt_ram.
module spt_dp #(
	parameter int PAGE_ENTRIES = 16384,
	parameter int RAM_BYTES    = 4194304
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spt_pkg::spt_cmd_t cmd,
	output spt_pkg::spt_sts_t sts,
	input  logic              in_valid,
	input  logic [2:0]        operation,
	input  logic [1:0]        segment,
	input  logic [27:0]       address,
	input  logic [2:0]        access_size,
	input  logic [31:0]       write_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [24:0]       physical_address,
	output logic [1:0]        fault_kind,
	output logic [31:0]       read_data
);

	localparam int IDX_W = $clog2(PAGE_ENTRIES);
	localparam logic [25:0] RamBytesC = 26'(RAM_BYTES);

	logic [2:0]  op_q;
	logic [1:0]  seg_q;
	logic [27:0] addr_q;
	logic [2:0]  size_q;
	logic [31:0] data_q;

	logic [15:0] base_q [3];
	logic [15:0] limit_q [2];

	logic [IDX_W-1:0] clr_cnt_q;

	logic        lim_fault_s1;
	logic [24:0] phys_q;
	logic [1:0]  fault_q;
	logic [31:0] rd_q;
	logic        out_valid_q;

	logic                        seg_low;
	logic [13:0]                 page;
	logic [15:0]                 limit;
	logic [15:0]                 base;
	logic [15:0]                 number;
	logic [IDX_W-1:0]            ram_addr;
	logic                        ram_we;
	logic [spt_pkg::ENTRY_W-1:0] ram_wdata;
	logic [spt_pkg::ENTRY_W-1:0] ram_rdata;

	logic [31:0] entry;
	logic [24:0] tr_addr;
	logic [25:0] tr_end;
	logic [24:0] phys_d;
	logic [1:0]  fault_d;
	logic [31:0] rd_d;

	always_ff @(posedge clk) begin
		if (cmd.idle && in_valid) begin
			op_q   <= operation;
			seg_q  <= segment;
			addr_q <= address;
			size_q <= access_size;
			data_q <= write_data;
		end
	end

	// lookup stage
	always_comb begin
		seg_low = (seg_q == spt_pkg::SEG_TEXT) || (seg_q == spt_pkg::SEG_STACK);
		page = addr_q[25:12];
		if (seg_q == spt_pkg::SEG_STACK) page = page ^ spt_pkg::PAGE_FIELD_MASK;
		limit = seg_low ? limit_q[seg_q[0]] : 16'd0;
		case (seg_q)
			spt_pkg::SEG_TEXT:   base = base_q[0];
			spt_pkg::SEG_STACK:  base = base_q[1];
			spt_pkg::SEG_KERNEL: base = base_q[2];
			default:             base = 16'd0;
		endcase
		if (seg_q == spt_pkg::SEG_STACK) begin
			number = base - {2'b00, page};
		end else begin
			number = base + {2'b00, page};
		end
		if (cmd.clear) begin
			ram_addr = clr_cnt_q;
		end else if (op_q == spt_pkg::OP_TRANSLATE) begin
			ram_addr = number[IDX_W-1:0];
		end else begin
			ram_addr = addr_q[2 +: IDX_W];
		end
		ram_we    = cmd.clear || (cmd.lookup && (op_q == spt_pkg::OP_PAGE_WR));
		ram_wdata = cmd.clear ? '0 : {data_q[31:28], data_q[12:0]};
	end

	spt_ram #(
		.WIDTH(spt_pkg::ENTRY_W),
		.DEPTH(PAGE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (cmd.lookup),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			base_q[0]  <= '0;
			base_q[1]  <= '0;
			base_q[2]  <= '0;
			limit_q[0] <= '0;
			limit_q[1] <= '0;
		end else begin
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.lookup && (op_q == spt_pkg::OP_BASE_WR)) begin
				if (seg_q == spt_pkg::SEG_KERNEL) begin
					base_q[2] <= {data_q[7:0], 8'h00};
				end else if (seg_low) begin
					base_q[seg_q] <= data_q[15:0];
				end
			end
			if (cmd.lookup && (op_q == spt_pkg::OP_LIMIT_WR) && seg_low) begin
				limit_q[seg_q[0]] <= data_q[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			lim_fault_s1 <= (limit != 16'd0) && ({2'b00, page} > limit);
		end
	end

	// result stage
	always_comb begin
		entry   = {ram_rdata[16:13], 15'd0, ram_rdata[12:0]};
		tr_addr = {ram_rdata[12:0], addr_q[11:0]};
		tr_end  = {1'b0, tr_addr} + 26'(size_q);
		phys_d  = '0;
		fault_d = spt_pkg::FAULT_NONE;
		rd_d    = '0;
		case (op_q)
			spt_pkg::OP_TRANSLATE: begin
				if (seg_q == spt_pkg::SEG_NONE) begin
					fault_d = spt_pkg::FAULT_NOPROT;
				end else if (lim_fault_s1) begin
					fault_d = spt_pkg::FAULT_LIMIT;
				end else if (ram_rdata[14:13] == 2'b00) begin
					fault_d = spt_pkg::FAULT_NOPROT;
				end else if (tr_end > RamBytesC) begin
					fault_d = spt_pkg::FAULT_RAM;
				end else begin
					phys_d = tr_addr;
				end
			end
			spt_pkg::OP_PAGE_RD: begin
				rd_d = entry;
			end
			spt_pkg::OP_BASE_RD: begin
				if (seg_q == spt_pkg::SEG_KERNEL) begin
					rd_d = {24'd0, base_q[2][15:8]};
				end else if (seg_low) begin
					rd_d = {16'd0, base_q[seg_q]};
				end
			end
			spt_pkg::OP_LIMIT_RD: begin
				if (seg_low) rd_d = {16'd0, limit_q[seg_q[0]]};
			end
			default: begin
				rd_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			phys_q  <= phys_d;
			fault_q <= fault_d;
			rd_q    <= rd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.clr_last = (clr_cnt_q == '1);
	assign sts.out_hold = out_valid_q && out_stall;

	assign out_valid        = out_valid_q;
	assign physical_address = phys_q;
	assign fault_kind       = fault_q;
	assign read_data        = rd_q;

endmodule

@@ rtl/segment_page_table_mmu_unit.sv @@
// Segmented MMU top level: spt_ctrl sequences, spt_dp holds segment registers and page table.
// Each request passes capture, single-port table read and the result register, all registered;
// a new request is taken only after the last one's result is loaded.
// Reset: clears state, then sweeps every page-table entry to zero,
// in_stall held high meanwhile. Depends on spt_pkg, spt_ctrl, spt_dp, spt_ram.
module segment_page_table_mmu_unit #(
	parameter int PAGE_ENTRIES = 16384,
	parameter int RAM_BYTES    = 4194304
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [1:0]  segment,
	input  logic [27:0] address,
	input  logic [2:0]  access_size,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [24:0] physical_address,
	output logic [1:0]  fault_kind,
	output logic [31:0] read_data
);

	spt_pkg::spt_cmd_t cmd;
	spt_pkg::spt_sts_t sts;

	spt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	spt_dp #(
		.PAGE_ENTRIES (PAGE_ENTRIES),
		.RAM_BYTES    (RAM_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_valid         (in_valid),
		.operation        (operation),
		.segment          (segment),
		.address          (address),
		.access_size      (access_size),
		.write_data       (write_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.physical_address (physical_address),
		.fault_kind       (fault_kind),
		.read_data        (read_data)
	);

	assign in_stall = !cmd.idle;

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> in_stall)
		else $error("request taken during table clear");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second request taken while one is in flight");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished request not presented");

	a_fault_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (fault_kind != spt_pkg::FAULT_NONE)) |-> (physical_address == 25'd0))
		else $error("faulted request carries an address");

endmodule

@@ dv/tb.sv @@
// Testbench for segment_page_table_mmu_unit: directed table, then random requests.
// Results are checked against an in-bench predictor of the segment registers and page table.
// Depends on spt_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int TABLE_DEPTH = 16384;
	localparam longint RAM_SIZE = 4194304;
	localparam logic [31:0] ENTRY_KEEP = 32'hf0001fff;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int ITEMS_PER_PHASE = 138;
	localparam int DIRECTED_ROWS = 29;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [24:0] phys;
		logic [1:0]  fault;
		logic [31:0] rd;
	} mmu_result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  seg;
		logic [27:0] addr;
		logic [2:0]  bytes;
		logic [31:0] wdata;
		logic        fixed;
		mmu_result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic [1:0]  segment;
	logic [27:0] address;
	logic [2:0]  access_size;
	logic [31:0] write_data;
	logic        out_valid;
	logic        out_stall;
	logic [24:0] physical_address;
	logic [1:0]  fault_kind;
	logic [31:0] read_data;

	logic [31:0] page_entry_q [TABLE_DEPTH];
	logic [15:0] seg_base_q [3];
	logic [15:0] seg_limit_q [3];

	mmu_result_t awaited_results [$];
	mmu_result_t seen_result;
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	dir_row_t directed_rows [DIRECTED_ROWS] = '{
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NOPROT, 32'h0}},
		'{spt_pkg::OP_PAGE_RD, spt_pkg::SEG_TEXT, 28'hffffffc, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'h0}},
		'{spt_pkg::OP_BASE_RD, spt_pkg::SEG_KERNEL, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'h0}},
		'{spt_pkg::OP_PAGE_WR, spt_pkg::SEG_TEXT, 28'h0, 3'd1, 32'hffffffff, 1'b0, '0},
		'{spt_pkg::OP_PAGE_RD, spt_pkg::SEG_TEXT, 28'h0010003, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'hf0001fff}},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'h0000fff, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_RAM, 32'h0}},
		'{spt_pkg::OP_PAGE_WR, spt_pkg::SEG_STACK, 28'h4, 3'd0, 32'h10000003, 1'b0, '0},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'h0001abc, 3'd4, 32'h0, 1'b1,
			'{25'h3abc, spt_pkg::FAULT_NONE, 32'h0}},
		'{spt_pkg::OP_PAGE_WR, spt_pkg::SEG_TEXT, 28'hffffffc, 3'd0, 32'h200003ff, 1'b0, '0},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'hfffffff, 3'd1, 32'h0, 1'b1,
			'{25'h3fffff, spt_pkg::FAULT_NONE, 32'h0}},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'hfffffff, 3'd2, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_RAM, 32'h0}},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_STACK, 28'hc000000, 3'd4, 32'h0, 1'b0, '0},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'h0001000, 3'd7, 32'h0, 1'b0, '0},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'h0, 3'd0, 32'h0, 1'b0, '0},
		'{spt_pkg::OP_BASE_WR, spt_pkg::SEG_KERNEL, 28'h0, 3'd1, 32'hffffffff, 1'b0, '0},
		'{spt_pkg::OP_BASE_RD, spt_pkg::SEG_KERNEL, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'hff}},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_KERNEL, 28'hfffffff, 3'd4, 32'h0, 1'b0, '0},
		'{spt_pkg::OP_BASE_WR, spt_pkg::SEG_TEXT, 28'h0, 3'd1, 32'h1234ffff, 1'b0, '0},
		'{spt_pkg::OP_BASE_RD, spt_pkg::SEG_TEXT, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'hffff}},
		'{spt_pkg::OP_LIMIT_WR, spt_pkg::SEG_KERNEL, 28'h0, 3'd1, 32'hffffffff, 1'b0, '0},
		'{spt_pkg::OP_LIMIT_RD, spt_pkg::SEG_KERNEL, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'h0}},
		'{spt_pkg::OP_LIMIT_WR, spt_pkg::SEG_TEXT, 28'h0, 3'd1, 32'h1, 1'b0, '0},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_TEXT, 28'h0002000, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_LIMIT, 32'h0}},
		'{spt_pkg::OP_LIMIT_WR, spt_pkg::SEG_STACK, 28'h0, 3'd1, 32'hffffffff, 1'b0, '0},
		'{spt_pkg::OP_LIMIT_RD, spt_pkg::SEG_STACK, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'hffff}},
		'{spt_pkg::OP_TRANSLATE, spt_pkg::SEG_NONE, 28'h0001abc, 3'd4, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NOPROT, 32'h0}},
		'{spt_pkg::OP_BASE_WR, spt_pkg::SEG_NONE, 28'h0, 3'd1, 32'hffffffff, 1'b0, '0},
		'{spt_pkg::OP_BASE_RD, spt_pkg::SEG_NONE, 28'h0, 3'd1, 32'h0, 1'b1,
			'{25'h0, spt_pkg::FAULT_NONE, 32'h0}},
		'{OP_UNUSED, spt_pkg::SEG_NONE, 28'hfffffff, 3'd7, 32'hffffffff, 1'b1, '0}
	};

	segment_page_table_mmu_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.segment(segment),
		.address(address),
		.access_size(access_size),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.physical_address(physical_address),
		.fault_kind(fault_kind),
		.read_data(read_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one request to the shadow state and returns what the block should answer.
	function automatic mmu_result_t mmu_compute(input logic [2:0] op, input logic [1:0] seg,
			input logic [27:0] addr, input logic [2:0] bytes, input logic [31:0] wdata);
		mmu_result_t res;
		logic [13:0] page;
		logic [15:0] number;
		logic [31:0] entry;
		logic [32:0] span;
		res = '0;
		case (op)
			spt_pkg::OP_TRANSLATE: begin
				if (seg == spt_pkg::SEG_NONE) begin
					res.fault = spt_pkg::FAULT_NOPROT;
				end else begin
					page = addr[25:12];
					if (seg == spt_pkg::SEG_STACK)
						page = ~page;
					if (seg_limit_q[seg] != 16'h0 && {2'b00, page} > seg_limit_q[seg]) begin
						res.fault = spt_pkg::FAULT_LIMIT;
					end else begin
						if (seg == spt_pkg::SEG_STACK)
							number = seg_base_q[seg] - {2'b00, page};
						else
							number = seg_base_q[seg] + {2'b00, page};
						entry = page_entry_q[number[13:0]];
						span = {8'h0, entry[12:0], addr[11:0]} + {30'h0, bytes};
						if (entry[29:28] == 2'b00)
							res.fault = spt_pkg::FAULT_NOPROT;
						else if (span > RAM_SIZE)
							res.fault = spt_pkg::FAULT_RAM;
						else
							res.phys = {entry[12:0], addr[11:0]};
					end
				end
			end
			spt_pkg::OP_PAGE_WR: page_entry_q[addr[15:2]] = wdata & ENTRY_KEEP;
			spt_pkg::OP_PAGE_RD: res.rd = page_entry_q[addr[15:2]];
			spt_pkg::OP_BASE_WR: begin
				if (seg == spt_pkg::SEG_KERNEL)
					seg_base_q[seg] = {wdata[7:0], 8'h00};
				else if (seg != spt_pkg::SEG_NONE)
					seg_base_q[seg] = wdata[15:0];
			end
			spt_pkg::OP_LIMIT_WR: begin
				if (seg == spt_pkg::SEG_TEXT || seg == spt_pkg::SEG_STACK)
					seg_limit_q[seg] = wdata[15:0];
			end
			spt_pkg::OP_BASE_RD: begin
				if (seg == spt_pkg::SEG_KERNEL)
					res.rd = {24'h0, seg_base_q[seg][15:8]};
				else if (seg != spt_pkg::SEG_NONE)
					res.rd = {16'h0, seg_base_q[seg]};
			end
			spt_pkg::OP_LIMIT_RD: begin
				if (seg == spt_pkg::SEG_TEXT || seg == spt_pkg::SEG_STACK)
					res.rd = {16'h0, seg_limit_q[seg]};
			end
			default: ;
		endcase
		return res;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic [2:0] op, input logic [1:0] seg,
			input logic [27:0] addr, input logic [2:0] bytes, input logic [31:0] wdata,
			input logic fixed, input mmu_result_t fixed_res);
		mmu_result_t res;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		segment <= seg;
		address <= addr;
		access_size <= bytes;
		write_data <= wdata;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		res = mmu_compute(op, seg, addr, bytes, wdata);
		awaited_results.push_back(fixed ? fixed_res : res);
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what, input mmu_result_t want,
			input mmu_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch (%s): expected phys %h fault %0d rd %h,",
				$realtime, what, want.phys, want.fault, want.rd,
				" got phys %h fault %0d rd %h", got.phys, got.fault, got.rd);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen_result = '{physical_address, fault_kind, read_data};
			if (awaited_results.size() == 0)
				note_mismatch("unexpected result", '0, seen_result);
			else if (seen_result !== awaited_results[0])
				note_mismatch("result", awaited_results.pop_front(), seen_result);
			else
				void'(awaited_results.pop_front());
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [2:0]  op;
		logic [1:0]  seg;
		logic [27:0] addr;
		logic [2:0]  bytes;
		logic [31:0] wdata;
		logic [13:0] page;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = spt_pkg::OP_TRANSLATE;
		segment = spt_pkg::SEG_TEXT;
		address = '0;
		access_size = 3'd1;
		write_data = '0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			page_entry_q[i] = '0;
		for (int s = 0; s < 3; s++) begin
			seg_base_q[s] = '0;
			seg_limit_q[s] = '0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].seg, directed_rows[i].addr,
				directed_rows[i].bytes, directed_rows[i].wdata, directed_rows[i].fixed,
				directed_rows[i].res);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				seg = ($urandom_range(19) == 0) ? spt_pkg::SEG_NONE : 2'($urandom_range(2));
				addr = 28'($urandom);
				bytes = 3'($urandom_range(1, 4));
				wdata = $urandom;
				// keep indexes near the bases so lookups mostly land on written entries
				page = ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(63));
				if (pick < 45) begin
					op = spt_pkg::OP_TRANSLATE;
					page = ($urandom_range(6) == 0) ? 14'($urandom) : 14'($urandom_range(15));
					addr[25:12] = (seg == spt_pkg::SEG_STACK) ? ~page : page;
					if ($urandom_range(9) == 0)
						bytes = 3'($urandom);
				end else if (pick < 63) begin
					op = spt_pkg::OP_PAGE_WR;
					addr[15:2] = page;
					wdata[12:0] = ($urandom_range(4) == 0) ? 13'($urandom)
						: 13'($urandom_range(1023));
					if ($urandom_range(4) != 0 && wdata[29:28] == 2'b00)
						wdata[29:28] = 2'($urandom_range(1, 3));
				end else if (pick < 72) begin
					op = spt_pkg::OP_PAGE_RD;
					addr[15:2] = page;
				end else if (pick < 82) begin
					op = spt_pkg::OP_BASE_WR;
					if ($urandom_range(4) != 0)
						wdata[15:0] = 16'($urandom_range(47));
					if (seg == spt_pkg::SEG_KERNEL && $urandom_range(3) != 0)
						wdata[7:0] = $urandom_range(1) ? 8'h40 : 8'h00;
				end else if (pick < 90) begin
					op = spt_pkg::OP_LIMIT_WR;
					pick = $urandom_range(9);
					if (pick < 5)
						wdata[15:0] = 16'h0;
					else if (pick < 9)
						wdata[15:0] = 16'($urandom_range(1, 20));
				end else if (pick < 96) begin
					op = $urandom_range(1) ? spt_pkg::OP_BASE_RD : spt_pkg::OP_LIMIT_RD;
				end else begin
					op = 3'($urandom_range(7));
					seg = 2'($urandom);
					bytes = 3'($urandom);
				end
				send_request(op, seg, addr, bytes, wdata, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
